/* design/rfpam_pkg.sv */
`timescale 1ns / 1ps

package rfpam_pkg;

    localparam int unsigned NUM_ALERTS = 5;
    localparam int unsigned NUM_REGS   = 8;
    localparam int unsigned REG_W      = 16;
    localparam int unsigned REG_IDX_W  = 3;
    localparam int unsigned BAND_W     = 4;
    localparam int unsigned PWR_W      = 16;
    localparam int unsigned SUP_W      = 8;

    localparam int unsigned TOP_BAND_DEF = 10;

    localparam logic [SUP_W-1:0] VDD_LOW   = 8'd45;
    localparam logic [SUP_W-1:0] VDD_HIGH  = 8'd75;
    localparam logic [SUP_W-1:0] IDD_FAULT = 8'd20;
    localparam logic [SUP_W-1:0] IDD_WARN  = 8'd18;

    // register indexes
    localparam logic [REG_IDX_W-1:0] R_FWD_WARN     = 3'd0;
    localparam logic [REG_IDX_W-1:0] R_FWD_FAULT    = 3'd1;
    localparam logic [REG_IDX_W-1:0] R_FWD_WARN_TOP = 3'd2;
    localparam logic [REG_IDX_W-1:0] R_FWD_FAULT_TOP = 3'd3;
    localparam logic [REG_IDX_W-1:0] R_RFL_WARN     = 3'd4;
    localparam logic [REG_IDX_W-1:0] R_RFL_FAULT    = 3'd5;
    localparam logic [REG_IDX_W-1:0] R_DRV_WARN     = 3'd6;
    localparam logic [REG_IDX_W-1:0] R_DRV_FAULT    = 3'd7;

    localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
        16'd600, 16'd660, 16'd410, 16'd482, 16'd450, 16'd590, 16'd900, 16'd1100
    };

    // alert indexes
    localparam int unsigned A_FWD = 0;
    localparam int unsigned A_RFL = 1;
    localparam int unsigned A_DRV = 2;
    localparam int unsigned A_VDD = 3;
    localparam int unsigned A_IDD = 4;

    typedef enum logic [1:0] {
        LVL_OFF    = 2'd0,
        LVL_NORMAL = 2'd1,
        LVL_WARN   = 2'd2,
        LVL_FAULT  = 2'd3
    } level_t;

    // fault from any level, warning only from normal
    function automatic level_t latch_level(level_t cur, logic [PWR_W-1:0] value,
                                           logic [PWR_W-1:0] warn,
                                           logic [PWR_W-1:0] fault);
        level_t res;
        res = cur;
        if (value > fault)
        begin
            res = LVL_FAULT;
        end
        else if (value > warn && cur == LVL_NORMAL)
        begin
            res = LVL_WARN;
        end
        return res;
    endfunction

endpackage

/* design/rf_protection_alert_monitor.sv */
`timescale 1ns / 1ps

// channel   dir  width              contents
// s_axis    in   tdata 72, tuser 1  sample or start-transmit word
// m_axis    out  tdata 16           alert levels, trip, changed mask
// cfg       in   idx 3, data 16     limit register write
//
// one word per cycle sustained while m_axis is not stalled; a word passes the input
// register then the result register, with the level state updated as it moves between them
// reset loads the default limits and clears all alert levels
// a stalled result holds; the input register keeps taking words until both
// stages are full

module rf_protection_alert_monitor
    import rfpam_pkg::*;
#(
    parameter int unsigned TOP_BAND = TOP_BAND_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // band, fwd_power, rfl_power, drv_power, supply_volts, supply_amps,
    // transmitting, attenuator_on, zero fill
    input  logic [71:0]          s_axis_tdata,
    // func
    input  logic [0:0]           s_axis_tuser,

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // fwd_level, rfl_level, drv_level, vdd_level, idd_level, trip, changed_mask
    output logic [15:0]          m_axis_tdata,

    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_idx,
    input  logic [REG_W-1:0]     cfg_data
);

    logic [REG_W-1:0] limit_reg [NUM_REGS];

    logic        in_valid_reg;
    logic [71:0] in_data_reg;
    logic        in_func_reg;

    logic        out_valid_reg;
    logic [15:0] out_data_reg;
    logic [15:0] out_data_next;

    level_t alert_reg [NUM_ALERTS];
    level_t shown_reg [NUM_ALERTS];
    level_t alert_next [NUM_ALERTS];
    level_t shown_next [NUM_ALERTS];

    logic advance;

    logic [BAND_W-1:0] band;
    logic [PWR_W-1:0]  fwd_power;
    logic [PWR_W-1:0]  rfl_power;
    logic [PWR_W-1:0]  drv_power;
    logic [SUP_W-1:0]  supply_volts;
    logic [SUP_W-1:0]  supply_amps;
    logic              transmitting;
    logic              attenuator_on;

    logic [PWR_W-1:0]      fwd_warn;
    logic [PWR_W-1:0]      fwd_fault;
    logic [NUM_ALERTS-1:0] mask;
    logic                  trip;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign band          = in_data_reg[3:0];
    assign fwd_power     = in_data_reg[19:4];
    assign rfl_power     = in_data_reg[35:20];
    assign drv_power     = in_data_reg[51:36];
    assign supply_volts  = in_data_reg[59:52];
    assign supply_amps   = in_data_reg[67:60];
    assign transmitting  = in_data_reg[68];
    assign attenuator_on = in_data_reg[69];

    always_comb
    begin
        alert_next = alert_reg;
        shown_next = shown_reg;
        mask       = '0;
        trip       = 1'b0;
        fwd_warn   = limit_reg[R_FWD_WARN];
        fwd_fault  = limit_reg[R_FWD_FAULT];
        if (band == BAND_W'(TOP_BAND))
        begin
            fwd_warn  = limit_reg[R_FWD_WARN_TOP];
            fwd_fault = limit_reg[R_FWD_FAULT_TOP];
        end

        if (in_func_reg)
        begin
            for (int i = 0; i < NUM_ALERTS; i++)
            begin
                alert_next[i] = LVL_NORMAL;
                shown_next[i] = LVL_OFF;
            end
        end
        else
        begin
            alert_next[A_FWD] = latch_level(alert_reg[A_FWD], fwd_power, fwd_warn, fwd_fault);
            alert_next[A_RFL] = latch_level(alert_reg[A_RFL], rfl_power,
                                            limit_reg[R_RFL_WARN], limit_reg[R_RFL_FAULT]);
            alert_next[A_DRV] = latch_level(alert_reg[A_DRV], drv_power,
                                            limit_reg[R_DRV_WARN], limit_reg[R_DRV_FAULT]);
            if (attenuator_on || !transmitting)
            begin
                alert_next[A_DRV] = LVL_OFF;
            end
            alert_next[A_VDD] = (supply_volts < VDD_LOW || supply_volts > VDD_HIGH)
                                ? LVL_WARN : LVL_NORMAL;
            alert_next[A_IDD] = latch_level(alert_reg[A_IDD], PWR_W'(supply_amps),
                                            PWR_W'(IDD_WARN), PWR_W'(IDD_FAULT));

            for (int i = 0; i < NUM_ALERTS; i++)
            begin
                mask[i]       = alert_next[i] != shown_reg[i];
                shown_next[i] = alert_next[i];
            end

            trip = (fwd_power > fwd_fault)
                || (rfl_power > limit_reg[R_RFL_FAULT])
                || (supply_amps > IDD_FAULT)
                || (mask[A_DRV] && alert_next[A_DRV] == LVL_FAULT && transmitting);
        end

        out_data_next = {mask, trip, alert_next[A_IDD], alert_next[A_VDD],
                         alert_next[A_DRV], alert_next[A_RFL], alert_next[A_FWD]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                limit_reg[i] <= REG_RESET[i];
            end
            for (int i = 0; i < NUM_ALERTS; i++)
            begin
                alert_reg[i] <= LVL_OFF;
                shown_reg[i] <= LVL_OFF;
            end
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg[cfg_idx] <= cfg_data;
            end

            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end

            if (advance)
            begin
                alert_reg     <= alert_next;
                shown_reg     <= shown_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata;
            in_func_reg <= s_axis_tuser[0];
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // start transmit yields no trip and an empty mask
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_func_reg) |=> (m_axis_tdata[15:10] == '0))
        else $error("start transmit result carries trip or change bits");

    // a trip always comes with a faulted alert
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[10]) |->
        (m_axis_tdata[1:0] == LVL_FAULT || m_axis_tdata[3:2] == LVL_FAULT
         || m_axis_tdata[5:4] == LVL_FAULT || m_axis_tdata[9:8] == LVL_FAULT))
        else $error("trip without a fault level");

    // supply voltage alert is never off in a result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:6] == LVL_NORMAL || m_axis_tdata[7:6] == LVL_WARN))
        else $error("voltage alert out of range");

endmodule
